/* sv/nbit_word_packer_defines.svh */
// Assertion macros used by the packer's top-level RTL file.
`ifndef NBIT_WORD_PACKER_DEFINES_SVH
`define NBIT_WORD_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define NWP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nbit_word_packer: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define NWP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nbit_word_packer: next-cycle check failed");

`endif

/* sv/nwp_pkg.sv */
// Package with the packer's constants, payload types and a helper function.
package nwp_pkg;

   localparam int BUFFER_BYTES   = 256;
   localparam int ADDR_BITS      = $clog2(BUFFER_BYTES);
   localparam int WORD_MAX       = 16;
   localparam int WIDTH_BITS     = 5;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIT_ORDER = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WORD_BITS = 4'd1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [WIDTH_BITS-1:0] WORD_BITS_RESET = 5'd8;

   typedef struct packed {
      logic        opcode;
      logic [10:0] word_slot;
      logic [15:0] word_data;
      logic [7:0]  byte_address;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       status;
   } rsp_type;

   // Operands of the shared byte merge unit.
   typedef struct packed {
      logic                  msb_first;
      logic [WIDTH_BITS-1:0] width;
      logic [2:0]            shift;
      logic [1:0]            byte_sel;
      logic [15:0]           data;
   } merge_op_type;

   // A width of zero packs one bit; anything above sixteen packs sixteen.
   function automatic logic [WIDTH_BITS-1:0] eff_width(input logic [WIDTH_BITS-1:0] w);
      logic [WIDTH_BITS-1:0] r;
      if (w == '0) begin
         r = WIDTH_BITS'(1);
      end else if (w > WIDTH_BITS'(WORD_MAX)) begin
         r = WIDTH_BITS'(WORD_MAX);
      end else begin
         r = w;
      end
      return r;
   endfunction

endpackage

/* sv/nwp_buffer.sv */
// Byte buffer with registered read and per-byte valid bits that reset clears.
module nwp_buffer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [nwp_pkg::ADDR_BITS-1:0] rd_addr,
   output logic [7:0]                  rd_data,
   input  logic                        wr_en,
   input  logic [nwp_pkg::ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]                  wr_data
);
   import nwp_pkg::*;

   logic [7:0]              mem [BUFFER_BYTES];
   logic [BUFFER_BYTES-1:0] valid_ff;
   logic [7:0]              rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // A byte never written since reset reads as zero.
   assign rd_data = rd_valid_ff ? rd_data_ff : 8'h00;

endmodule

/* sv/nwp_merge.sv */
// Shared shift-and-mask unit that merges one byte of a packed word into an old byte.
module nwp_merge (
   input  nwp_pkg::merge_op_type op,
   input  logic [7:0]            old_byte,
   output logic [7:0]            new_byte
);
   import nwp_pkg::*;

   logic [WIDTH_BITS-1:0] gap;
   logic [15:0]           lo_mask;
   logic [15:0]           hi_mask;
   logic [23:0]           win;
   logic [23:0]           win_mask;
   logic [1:0]            slot;
   logic [7:0]            v;
   logic [7:0]            m;

   always_comb begin
      gap     = WIDTH_BITS'(WORD_MAX) - op.width;
      lo_mask = 16'hFFFF >> gap;
      hi_mask = 16'hFFFF << gap;
      // In MSB-first order the window is laid out with stream position zero at the top,
      // so each byte slice already has the right bit order.
      if (op.msb_first) begin
         win      = {op.data & hi_mask, 8'h00} >> op.shift;
         win_mask = {hi_mask, 8'h00} >> op.shift;
         slot     = 2'd2 - op.byte_sel;
      end else begin
         win      = {8'h00, op.data & lo_mask} << op.shift;
         win_mask = {8'h00, lo_mask} << op.shift;
         slot     = op.byte_sel;
      end
      unique case (slot)
         2'd0: begin
            v = win[7:0];
            m = win_mask[7:0];
         end
         2'd1: begin
            v = win[15:8];
            m = win_mask[15:8];
         end
         2'd2: begin
            v = win[23:16];
            m = win_mask[23:16];
         end
         default: begin
            v = 8'h00;
            m = 8'h00;
         end
      endcase
      new_byte = (old_byte & ~m) | (v & m);
   end

endmodule

/* sv/nbit_word_packer.sv */
// Top level of the bit packer: sequencer, configuration registers and result register.
//
// Packs words of 1 to 16 bits into a byte buffer, or reads one byte back.
// req_valid/req_ready carry one operation (write a packed word or read a byte);
// rsp_valid/rsp_ready return one result per operation, in order. csr_valid/csr_ready
// write bit_order (index 0) or word_bits (index 1); csr_ready is always high and
// other indexes are ignored. Configure only while no operation is outstanding.
// A write touches n = 1 to 3 bytes, each a read then a write of the byte memory
// through the shared merge unit; a read makes one memory read and an out-of-range
// operation none. req_ready is high only while the sequencer is idle, so a new
// operation is accepted only after the last one has gone through the done state.
// A finished result sits in the output register while the next operation is
// accepted; a stalled receiver holds the following result back.
// Reset clears the buffer to zero at once (valid bits), sets bit_order to LSB first
// and word_bits to 8.
module nbit_word_packer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  nwp_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output nwp_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nwp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [nwp_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import nwp_pkg::*;
   `include "nbit_word_packer_defines.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_RD,
      ST_WR,
      ST_DONE
   } state_type;

   state_type             state_ff;
   logic                  op_ff;
   logic [10:0]           widx_ff;
   logic [15:0]           data_ff;
   logic [7:0]            addr_ff;
   logic [ADDR_BITS-1:0]  base_ff;
   logic [2:0]            shift_ff;
   logic [1:0]            last_rel_ff;
   logic [1:0]            byte_sel_ff;
   logic                  status_ff;
   logic [7:0]            rbyte_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;
   logic                  bit_order_ff;
   logic [WIDTH_BITS-1:0] word_bits_ff;

   logic [WIDTH_BITS-1:0] width;
   logic [15:0]           offset;
   logic [15:0]           last_pos;
   logic [WIDTH_BITS-1:0] last_in_win;
   logic                  wr_range_err;
   logic                  rd_range_err;
   logic [ADDR_BITS-1:0]  mem_addr;
   logic                  mem_rd_en;
   logic                  mem_wr_en;
   logic [7:0]            mem_rd_data;
   logic [7:0]            merged;
   merge_op_type          merge_op;

   assign width        = eff_width(word_bits_ff);
   assign offset       = 16'(widx_ff) * 16'(width);
   assign last_pos     = offset + 16'(width) - 16'd1;
   assign last_in_win  = WIDTH_BITS'(offset[2:0]) + width - WIDTH_BITS'(1);
   assign wr_range_err = 32'(last_pos[15:3]) >= 32'(BUFFER_BYTES);
   assign rd_range_err = 32'(addr_ff) >= 32'(BUFFER_BYTES);

   assign mem_addr  = (op_ff == OP_READ) ? ADDR_BITS'(addr_ff)
                                         : base_ff + ADDR_BITS'(byte_sel_ff);
   assign mem_rd_en = (state_ff == ST_RD);
   assign mem_wr_en = (state_ff == ST_WR) && (op_ff == OP_WRITE);

   assign merge_op.msb_first = bit_order_ff;
   assign merge_op.width     = width;
   assign merge_op.shift     = shift_ff;
   assign merge_op.byte_sel  = byte_sel_ff;
   assign merge_op.data      = data_ff;

   nwp_buffer u_buffer (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (merged)
   );

   nwp_merge u_merge (
      .op       (merge_op),
      .old_byte (mem_rd_data),
      .new_byte (merged)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_order_ff <= 1'b0;
         word_bits_ff <= WORD_BITS_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_BIT_ORDER) begin
            bit_order_ff <= csr_data[0];
         end else if (csr_index == CSR_WORD_BITS) begin
            word_bits_ff <= csr_data[WIDTH_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the done state the result register is reloaded instead.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff     <= req_payload.opcode;
                  widx_ff   <= req_payload.word_slot;
                  data_ff   <= req_payload.word_data;
                  addr_ff   <= req_payload.byte_address;
                  status_ff <= 1'b0;
                  rbyte_ff  <= 8'h00;
                  state_ff  <= ST_CALC;
               end
            end
            ST_CALC: begin
               byte_sel_ff <= 2'd0;
               base_ff     <= ADDR_BITS'(offset >> 3);
               shift_ff    <= offset[2:0];
               last_rel_ff <= last_in_win[4:3];
               if (op_ff == OP_READ) begin
                  status_ff <= rd_range_err;
                  state_ff  <= rd_range_err ? ST_DONE : ST_RD;
               end else begin
                  status_ff <= wr_range_err;
                  state_ff  <= wr_range_err ? ST_DONE : ST_RD;
               end
            end
            ST_RD: begin
               state_ff <= ST_WR;
            end
            ST_WR: begin
               if (op_ff == OP_READ) begin
                  rbyte_ff <= mem_rd_data;
                  state_ff <= ST_DONE;
               end else if (byte_sel_ff == last_rel_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  byte_sel_ff <= byte_sel_ff + 2'd1;
                  state_ff    <= ST_RD;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.read_byte <= rbyte_ff;
                  rsp_ff.status    <= status_ff;
                  rsp_valid_ff     <= 1'b1;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   `NWP_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == ST_CALC)
   `NWP_ASSERT_NOW(a_write_only_merge, clock, reset, mem_wr_en, state_ff == ST_WR && op_ff == OP_WRITE)
   `NWP_ASSERT_NOW(a_byte_sel_bound, clock, reset, state_ff == ST_WR, byte_sel_ff <= last_rel_ff)
   `NWP_ASSERT_NEXT(a_range_drop, clock, reset, state_ff == ST_CALC && op_ff == OP_WRITE && wr_range_err, state_ff == ST_DONE && status_ff)

endmodule
